FILE: src/lgt_pkg.sv
// ----------------------------------------------------------------------------
// lgt_pkg
// Shared types and constants for the toroidal Life grid: key codes, run
// modes, the start pattern, the preset patterns and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lgt_pkg;

	localparam int unsigned GRID_MAX = 8;
	localparam int unsigned GRID_BITS = GRID_MAX * GRID_MAX;
	localparam int unsigned NUM_PRESETS = 4;

	localparam logic [7:0] KEY_STAR = 8'h2A;
	localparam logic [7:0] KEY_ZERO = 8'h30;
	localparam logic [7:0] KEY_ONE = 8'h31;
	localparam logic [7:0] KEY_FOUR = 8'h34;

	typedef enum logic [1:0] {
		MODE_RUN = 2'd0,
		MODE_PAUSE = 2'd1,
		MODE_STEP = 2'd2
	} lgt_mode_t;

	// Control bundle broadcast from the mode controller to every cell
	typedef struct packed {
		logic advance;
		logic load;
		logic [1:0] preset_sel;
	} lgt_ctl_t;

	localparam logic [GRID_BITS-1:0] START_PATTERN = 64'h00E0001818060600;

	localparam logic [GRID_BITS-1:0] PRESETS [NUM_PRESETS] = '{
		64'h233B0D0480990982,
		64'h0818215AA15A2488,
		64'hE098100022460500,
		64'h0000001C10080000
	};

endpackage

`default_nettype wire

FILE: src/lgt_item_if.sv
// ----------------------------------------------------------------------------
// lgt_item_if
// Input channel: timer tick or key press, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgt_item_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [7:0] key_code;

	modport source (output valid, output cmd, output key_code, input ready);
	modport sink (input valid, input cmd, input key_code, output ready);
endinterface

`default_nettype wire

FILE: src/lgt_result_if.sv
// ----------------------------------------------------------------------------
// lgt_result_if
// Output channel: grid, run mode and advance flag, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgt_result_if;
	logic valid;
	logic ready;
	logic [63:0] grid_bits;
	logic [1:0] run_mode;
	logic advanced;

	modport source (output valid, output grid_bits, output run_mode, output advanced,
		input ready);
	modport sink (input valid, input grid_bits, input run_mode, input advanced,
		output ready);
endinterface

`default_nettype wire

FILE: src/lgt_cell.sv
// ----------------------------------------------------------------------------
// lgt_cell
// One grid cell: holds its own state and applies B3/S23 from the eight
// neighbour states, or loads its bit of the selected preset.
// ----------------------------------------------------------------------------
`default_nettype none

module lgt_cell #(
	parameter logic RST_ALIVE = 1'b0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire lgt_pkg::lgt_ctl_t ctl,
	input  wire logic [lgt_pkg::NUM_PRESETS-1:0] preset_bits,
	input  wire logic [7:0] nbrs,
	output logic alive
);

	logic alive_q;
	logic [3:0] count;
	logic alive_d;

	always_comb begin
		count = 4'd0;
		for (int i = 0; i < 8; i++) begin
			count = count + {3'd0, nbrs[i]};
		end
	end

	always_comb begin
		alive_d = alive_q;
		if (ctl.load) begin
			alive_d = preset_bits[ctl.preset_sel];
		end else if (ctl.advance) begin
			alive_d = (count == 4'd3) || (alive_q && (count == 4'd2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= RST_ALIVE;
		end else begin
			alive_q <= alive_d;
		end
	end

	assign alive = alive_q;

endmodule

`default_nettype wire

FILE: src/lgt_ctrl.sv
// ----------------------------------------------------------------------------
// lgt_ctrl
// Run mode state machine; decodes ticks and keys into cell controls.
// ----------------------------------------------------------------------------
`default_nettype none

module lgt_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic accept,
	input  wire logic cmd,
	input  wire logic [7:0] key_code,
	output lgt_pkg::lgt_ctl_t ctl,
	output lgt_pkg::lgt_mode_t mode
);

	lgt_pkg::lgt_mode_t mode_q;
	lgt_pkg::lgt_mode_t mode_d;
	logic [1:0] key_off;
	logic is_preset;

	// Preset index: only the low two bits of the key offset matter
	assign key_off = key_code[1:0] - lgt_pkg::KEY_ONE[1:0];
	assign is_preset = (key_code >= lgt_pkg::KEY_ONE) && (key_code <= lgt_pkg::KEY_FOUR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lgt_pkg::MODE_RUN;
		end else begin
			mode_q <= mode_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		ctl.advance = 1'b0;
		ctl.load = 1'b0;
		ctl.preset_sel = key_off;
		if (accept) begin
			if (!cmd) begin
				case (mode_q)
					lgt_pkg::MODE_RUN: begin
						ctl.advance = 1'b1;
					end
					lgt_pkg::MODE_STEP: begin
						ctl.advance = 1'b1;
						mode_d = lgt_pkg::MODE_PAUSE;
					end
					default: begin
						mode_d = mode_q;
					end
				endcase
			end else if (is_preset) begin
				ctl.load = 1'b1;
				mode_d = lgt_pkg::MODE_RUN;
			end else if (key_code == lgt_pkg::KEY_STAR) begin
				mode_d = (mode_q == lgt_pkg::MODE_RUN) ? lgt_pkg::MODE_PAUSE
					: lgt_pkg::MODE_RUN;
			end else if (key_code == lgt_pkg::KEY_ZERO && mode_q == lgt_pkg::MODE_PAUSE) begin
				mode_d = lgt_pkg::MODE_STEP;
			end
		end
	end

	assign mode = mode_q;

endmodule

`default_nettype wire

FILE: src/life_grid_8x8_torus.sv
// ----------------------------------------------------------------------------
// life_grid_8x8_torus
// Conway Life (B3/S23) on a GRID_SIZE x GRID_SIZE torus with run control.
// ----------------------------------------------------------------------------
// Each item on the input channel is a timer tick (cmd 0) or a key press
// (cmd 1), and each gives exactly one result: the grid after the item, the run
// mode after it, and a flag set when a new generation was computed. Every cell
// of the grid is its own small unit holding one bit; on an advancing tick all
// cells compute the next generation together from the eight wrapped neighbours,
// so an item is taken every cycle and its result shows in the cycle after. The
// result register is the cell state itself plus a valid and an advance flag;
// a new item is taken while the previous result is being transferred, and the
// input stalls only while a result waits unclaimed. Keys '1'..'4' load preset
// patterns and set running, '*' pauses when running and sets running otherwise,
// and '0' from paused arms a single step. Cells outside GRID_SIZE always read 0.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_8x8_torus #(
	parameter int unsigned GRID_SIZE = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lgt_item_if.sink item,
	lgt_result_if.source result
);

	lgt_pkg::lgt_ctl_t ctl;
	lgt_pkg::lgt_mode_t mode;
	logic accept;
	logic valid_q;
	logic adv_q;
	logic [lgt_pkg::GRID_BITS-1:0] grid;

	// Take a new item whenever the result slot is empty or being emptied
	assign item.ready = !valid_q || result.ready;
	assign accept = item.valid && item.ready;

	lgt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cmd(item.cmd),
		.key_code(item.key_code),
		.ctl(ctl),
		.mode(mode)
	);

	// Build the cell array; neighbours wrap at GRID_SIZE, not at the full width
	for (genvar r = 0; r < lgt_pkg::GRID_MAX; r++) begin : g_row
		for (genvar c = 0; c < lgt_pkg::GRID_MAX; c++) begin : g_col
			if (r < GRID_SIZE && c < GRID_SIZE) begin : g_cell
				localparam int unsigned RU = (r + GRID_SIZE - 1) % GRID_SIZE;
				localparam int unsigned RD = (r + 1) % GRID_SIZE;
				localparam int unsigned CL = (c + GRID_SIZE - 1) % GRID_SIZE;
				localparam int unsigned CR = (c + 1) % GRID_SIZE;
				localparam int unsigned IDX = r * lgt_pkg::GRID_MAX + c;

				logic [lgt_pkg::NUM_PRESETS-1:0] preset_bits;
				logic [7:0] nbrs;

				for (genvar p = 0; p < lgt_pkg::NUM_PRESETS; p++) begin : g_pre
					assign preset_bits[p] = lgt_pkg::PRESETS[p][IDX];
				end

				assign nbrs = {
					grid[RU * lgt_pkg::GRID_MAX + CL],
					grid[RU * lgt_pkg::GRID_MAX + c],
					grid[RU * lgt_pkg::GRID_MAX + CR],
					grid[r * lgt_pkg::GRID_MAX + CL],
					grid[r * lgt_pkg::GRID_MAX + CR],
					grid[RD * lgt_pkg::GRID_MAX + CL],
					grid[RD * lgt_pkg::GRID_MAX + c],
					grid[RD * lgt_pkg::GRID_MAX + CR]
				};

				lgt_cell #(
					.RST_ALIVE(lgt_pkg::START_PATTERN[IDX])
				) u_cell (
					.clk(clk),
					.arst_n(arst_n),
					.ctl(ctl),
					.preset_bits(preset_bits),
					.nbrs(nbrs),
					.alive(grid[IDX])
				);
			end else begin : g_empty
				assign grid[r * lgt_pkg::GRID_MAX + c] = 1'b0;
			end
		end
	end

	// Hold the result until transferred; advance flag follows the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			adv_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_q <= 1'b1;
				adv_q <= ctl.advance;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result.valid = valid_q;
	assign result.grid_bits = grid;
	assign result.run_mode = mode;
	assign result.advanced = adv_q;

endmodule

`default_nettype wire

FILE: tb/lgt_grid_checker.sv
// ----------------------------------------------------------------------------
// lgt_grid_checker
// Watches both channels of the Life grid, predicts each result from its own
// copy of the grid and run mode, and counts every disagreement.
// ----------------------------------------------------------------------------

package lgt_tb_pkg;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KEY = 1'b1;

	typedef struct packed {
		logic [63:0] grid;
		logic [1:0] mode;
		logic adv;
	} grid_outcome_t;

endpackage

module lgt_grid_checker #(
	parameter int unsigned GRID_SIZE = 8
) (
	input  logic clk,
	input  logic arst_n,
	lgt_item_if item,
	lgt_result_if result,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import lgt_pkg::*;
	import lgt_tb_pkg::*;

	function automatic logic [63:0] grid_window();
		logic [63:0] m;
		m = '0;
		for (int r = 0; r < GRID_SIZE; r++)
			for (int c = 0; c < GRID_SIZE; c++)
				m[r*8+c] = 1'b1;
		return m;
	endfunction

	localparam logic [63:0] LIVE_MASK = grid_window();

	// B3/S23, neighbours wrap round the torus
	function automatic logic [63:0] life_generation(input logic [63:0] g);
		logic [63:0] nxt;
		int unsigned cnt;
		int rr;
		int cc;
		nxt = '0;
		for (int r = 0; r < GRID_SIZE; r++) begin
			for (int c = 0; c < GRID_SIZE; c++) begin
				cnt = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if (dr != 0 || dc != 0) begin
							rr = (r + dr + GRID_SIZE) % GRID_SIZE;
							cc = (c + dc + GRID_SIZE) % GRID_SIZE;
							cnt += g[rr*8+cc];
						end
					end
				end
				if (cnt == 3 || (g[r*8+c] && cnt == 2))
					nxt[r*8+c] = 1'b1;
			end
		end
		return nxt;
	endfunction

	function automatic grid_outcome_t apply_item(input grid_outcome_t now, input logic cmd,
		input logic [7:0] code);
		grid_outcome_t nxt;
		logic [7:0] sel;
		nxt = now;
		nxt.adv = 1'b0;
		if (cmd == CMD_TICK) begin
			if (now.mode == MODE_RUN || now.mode == MODE_STEP) begin
				nxt.grid = life_generation(now.grid);
				nxt.adv = 1'b1;
				if (now.mode == MODE_STEP)
					nxt.mode = MODE_PAUSE;
			end
		end else if (code >= KEY_ONE && code <= KEY_FOUR) begin
			sel = code - KEY_ONE;
			nxt.grid = PRESETS[sel[1:0]];
			nxt.mode = MODE_RUN;
		end else if (code == KEY_STAR) begin
			nxt.mode = (now.mode == MODE_RUN) ? MODE_PAUSE : MODE_RUN;
		end else if (code == KEY_ZERO && now.mode == MODE_PAUSE) begin
			nxt.mode = MODE_STEP;
		end
		nxt.grid &= LIVE_MASK;
		return nxt;
	endfunction

	grid_outcome_t shadow;
	grid_outcome_t due_grids[$];
	int unsigned faults;

	always @(posedge clk or negedge arst_n) begin
		grid_outcome_t want;
		if (!arst_n) begin
			shadow = '{grid: START_PATTERN & LIVE_MASK, mode: MODE_RUN, adv: 1'b0};
			due_grids.delete();
			faults = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// retire the result first: it always belongs to an earlier transfer
			if (result.valid && result.ready) begin
				if (due_grids.size() == 0) begin
					$display("%0t: unexpected result grid %h mode %0d advanced %0d",
						$time, result.grid_bits, result.run_mode, result.advanced);
					faults++;
				end else begin
					want = due_grids.pop_front();
					if (result.grid_bits !== want.grid) begin
						$display("%0t: grid_bits expected %h actual %h",
							$time, want.grid, result.grid_bits);
						faults++;
					end
					if (result.run_mode !== want.mode) begin
						$display("%0t: run_mode expected %0d actual %0d",
							$time, want.mode, result.run_mode);
						faults++;
					end
					if (result.advanced !== want.adv) begin
						$display("%0t: advanced expected %0d actual %0d",
							$time, want.adv, result.advanced);
						faults++;
					end
				end
			end
			if (item.valid && item.ready) begin
				shadow = apply_item(shadow, item.cmd, item.key_code);
				due_grids.push_back(shadow);
			end
			fail_count <= faults;
			outstanding <= due_grids.size();
		end
	end

endmodule

FILE: tb/tb_life_grid_8x8_torus.sv
// ----------------------------------------------------------------------------
// tb_life_grid_8x8_torus
// Stimulus and verdict for the toroidal Life grid. A directed opening walks
// through every run mode, every key and the field extremes; a long random
// stretch of ticks and keys follows, with random gaps on both channels. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_life_grid_8x8_torus;
	timeunit 1ns;
	timeprecision 1ps;

	import lgt_pkg::*;
	import lgt_tb_pkg::*;

	// Generous bound: every transfer may meet gaps on both sides
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_ITEMS = 1800;
	localparam int unsigned DRAIN_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;
	// High while neither side may idle
	bit calm = 1'b0;
	int unsigned cycles = 0;
	int unsigned fail_count;
	int unsigned outstanding;

	lgt_item_if item_ch();
	lgt_result_if result_ch();

	life_grid_8x8_torus DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	lgt_grid_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop, in case a result never turns up
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: drop ready at random, with a chance of seven in a hundred,
	// never while the calm stretch runs.
	always @(posedge clk) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= calm || ($urandom_range(99) >= 7);
	end

	// Offer one item and hold it until the block takes it. Gaps go in front
	// of the item, so valid never drops while an item is on offer, and a
	// back-to-back item keeps valid high without a glitch.
	task automatic post_item(input logic cmd, input logic [7:0] code);
		while (!calm && $urandom_range(99) < 7) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= cmd;
		item_ch.key_code <= code;
		do
			@(posedge clk);
		while (!item_ch.ready);
	endtask

	task automatic press(input logic [7:0] code);
		post_item(CMD_KEY, code);
	endtask

	task automatic tick(input logic [7:0] code);
		post_item(CMD_TICK, code);
	endtask

	initial begin
		int unsigned counted;
		int unsigned roll;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_TICK;
		item_ch.key_code = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start pattern is running out of reset: let it advance, once with a
		// tick that carries a full key byte, which must be ignored.
		tick(8'h00);
		tick(8'hFF);
		// Pause, tick while paused, arm a step, a second '0' while armed,
		// take the step and fall back to paused.
		press(KEY_STAR);
		tick(8'h00);
		press(KEY_ZERO);
		press(KEY_ZERO);
		tick(8'h00);
		tick(8'h00);
		// '*' from step pending goes to running; toggle both ways; '0' while
		// running is ignored.
		press(KEY_ZERO);
		press(KEY_STAR);
		press(KEY_STAR);
		press(KEY_STAR);
		press(KEY_ZERO);
		// Every preset, each followed by a generation
		press(KEY_ONE);
		tick(8'h00);
		press(KEY_ONE + 8'd1);
		tick(8'h00);
		press(KEY_ONE + 8'd2);
		tick(8'h00);
		press(KEY_FOUR);
		tick(8'h00);
		// Keys that do nothing: null, all ones, just past the presets, just
		// below '0'
		press(8'h00);
		press(8'hFF);
		press(KEY_FOUR + 8'd1);
		press(KEY_ZERO - 8'd1);

		// Random part: mostly ticks, so patterns evolve for many generations,
		// with presets reloading fresh material, mode keys steering the run
		// and the odd stray key or tick mixed in.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			calm = (counted >= 700 && counted < 1000);
			roll = $urandom_range(99);
			if (roll < 50) begin
				tick(8'($urandom_range(255)));
			end else if (roll < 58) begin
				press(KEY_ONE + 8'($urandom_range(3)));
			end else if (roll < 68) begin
				press(KEY_STAR);
			end else if (roll < 78) begin
				press(KEY_ZERO);
			end else begin
				post_item(1'($urandom_range(1)), 8'($urandom_range(255)));
			end
			counted++;
		end
		item_ch.valid <= 1'b0;
		calm = 1'b0;

		// Let the count of results in flight catch up with the last
		// transfer, drain, then let the block run on to show anything stray
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
